/* rtl/loudspeaker_motion_step_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the loudspeaker motion step block
// Implication and next-cycle forms, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef LOUDSPEAKER_MOTION_STEP_ASSERT_SVH
`define LOUDSPEAKER_MOTION_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define LMS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LMS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LMS_ASSERT_IMP(name, clk, rst, ante, cons)
`define LMS_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

/* rtl/lms_pkg.sv */
// ----------------------------------------------------------------------------
// lms_pkg
// Types, constants and saturation helper for the loudspeaker motion step.
// ----------------------------------------------------------------------------
`default_nettype none

package lms_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int Q_W        = 32;
   localparam int CFG_W      = 31;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

   typedef enum logic [1:0] {
      STATUS_UPDATED,
      STATUS_SKIPPED,
      STATUS_PARAM_ERROR
   } status_type;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctrl_type;

   typedef struct packed {
      logic done;
   } alu_stat_type;

   typedef struct packed {
      logic signed [Q_W-1:0] drive_voltage;
      logic signed [Q_W-1:0] pressure_left;
      logic signed [Q_W-1:0] pressure_right;
      logic [CFG_W-1:0]      air_mass;
   } req_type;

   typedef struct packed {
      status_type            step_status;
      logic signed [Q_W-1:0] coil_current;
      logic signed [Q_W-1:0] diaphragm_velocity;
      logic signed [Q_W-1:0] diaphragm_position;
   } rsp_type;

   function automatic logic signed [Q_W-1:0] sat32(input logic signed [2*Q_W-1:0] v);
      priority if (v > (2*Q_W)'(Q_MAX)) begin
         return Q_MAX;
      end else if (v < (2*Q_W)'(Q_MIN)) begin
         return Q_MIN;
      end else begin
         return v[Q_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/lms_alu.sv */
// ----------------------------------------------------------------------------
// lms_alu
// Shared fixed-point unit: saturating multiply, and divide two bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lms_alu (
   input  wire                               clock,
   input  wire                               reset,
   input  wire lms_pkg::alu_ctrl_type        ctrl,
   input  wire logic signed [lms_pkg::Q_W-1:0] opa,
   input  wire logic signed [lms_pkg::Q_W-1:0] opb,
   output lms_pkg::alu_stat_type             stat,
   output logic signed [lms_pkg::Q_W-1:0]    result
);
   import lms_pkg::*;

   localparam int DVD_W      = Q_W + FRAC_BITS;
   localparam int STEP_BITS  = 2;
   localparam int DIV_CYCLES = Q_W / STEP_BITS;
   localparam int CNT_W      = $clog2(DIV_CYCLES);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

   typedef enum logic [1:0] {
      A_IDLE,
      A_MUL,
      A_DIV,
      A_FIN
   } alu_state_type;

   alu_state_type             state_ff;
   logic signed [2*Q_W-1:0]   prod_ff;
   logic [Q_W-1:0]            rem_ff;
   logic [Q_W-1:0]            quo_ff;
   logic [Q_W-2:0]            dsr_ff;
   logic                      neg_ff;
   logic                      ovf_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic signed [Q_W-1:0]     res_ff;
   logic                      done_ff;

   logic signed [2*Q_W-1:0]   prod_in;
   logic [Q_W-1:0]            mag_a;
   logic [DVD_W-1:0]          dvd;
   logic [FRAC_BITS-1:0]      dvd_hi;
   logic                      ovf_start;
   logic [2*Q_W-1:0]          step1;
   logic [2*Q_W-1:0]          step2;
   logic [Q_W-1:0]            mag_q;
   logic signed [2*Q_W-1:0]   quo_signed;

   function automatic logic [2*Q_W-1:0] div_step(input logic [Q_W-1:0] rem,
                                                 input logic [Q_W-1:0] quo,
                                                 input logic [Q_W-2:0] dsr);
      logic [Q_W:0] trial;
      logic [Q_W:0] dext;
      logic         take;
      trial = {rem, quo[Q_W-1]};
      dext  = {2'b00, dsr};
      take  = (trial >= dext);
      if (take) begin
         trial = trial - dext;
      end
      return {trial[Q_W-1:0], quo[Q_W-2:0], take};
   endfunction

   assign prod_in   = (2*Q_W)'(opa) * (2*Q_W)'(opb);
   assign mag_a     = opa[Q_W-1] ? (~opa + 1'b1) : opa;
   assign dvd       = {mag_a, {FRAC_BITS{1'b0}}};
   assign dvd_hi    = dvd[DVD_W-1:Q_W];
   assign ovf_start = (Q_W'(dvd_hi) >= {1'b0, opb[Q_W-2:0]});
   assign step1     = div_step(rem_ff, quo_ff, dsr_ff);
   assign step2     = div_step(step1[2*Q_W-1:Q_W], step1[Q_W-1:0], dsr_ff);
   assign mag_q     = ovf_ff ? {Q_W{1'b1}} : quo_ff;
   assign quo_signed = neg_ff ? -(2*Q_W)'(mag_q) : (2*Q_W)'(mag_q);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == A_MUL) || (state_ff == A_FIN);
         unique case (state_ff)
            A_IDLE: begin
               if (ctrl.start) begin
                  unique case (ctrl.op)
                     ALU_MUL: begin
                        prod_ff  <= prod_in;
                        state_ff <= A_MUL;
                     end
                     ALU_DIV: begin
                        neg_ff   <= opa[Q_W-1];
                        dsr_ff   <= opb[Q_W-2:0];
                        ovf_ff   <= ovf_start;
                        rem_ff   <= Q_W'(dvd_hi);
                        quo_ff   <= dvd[Q_W-1:0];
                        cnt_ff   <= '0;
                        state_ff <= ovf_start ? A_FIN : A_DIV;
                     end
                  endcase
               end
            end
            A_MUL: begin
               res_ff   <= sat32(prod_ff >>> FRAC_BITS);
               state_ff <= A_IDLE;
            end
            A_DIV: begin
               rem_ff <= step2[2*Q_W-1:Q_W];
               quo_ff <= step2[Q_W-1:0];
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  state_ff <= A_FIN;
               end
            end
            A_FIN: begin
               res_ff   <= sat32(quo_signed);
               state_ff <= A_IDLE;
            end
         endcase
      end
   end

   assign stat.done = done_ff;
   assign result    = res_ff;

endmodule

`default_nettype wire

/* rtl/loudspeaker_motion_step.sv */
// ----------------------------------------------------------------------------
// loudspeaker_motion_step
// One semi-implicit Euler step of a lumped loudspeaker model per item.
// ----------------------------------------------------------------------------
//  channel  | ports                           | role
//  ---------+---------------------------------+------------------------------
//  request  | req_valid, req_stall, req_data  | drive voltage, pressures, air
//  response | rsp_valid, rsp_stall, rsp_data  | status, current, velocity, pos
//  config   | psel..pready                    | eight unsigned Q15.16 parameters
//
//  An updating item runs 8 multiplies and 5 divides in turn on the shared unit;
//  a divide develops 2 quotient bits per iteration, or skips the iterations
//  when the quotient overflows. A skipped or error item goes straight to the
//  final state. Synchronous reset clears state and parameters. req_stall is
//  high while an item is in work; a waiting response item holds the sequencer
//  in its final state until taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "loudspeaker_motion_step_assert.svh"

module loudspeaker_motion_step (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire lms_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output lms_pkg::rsp_type                       rsp_data,
   input  wire                                    psel,
   input  wire                                    penable,
   input  wire                                    pwrite,
   input  wire logic [lms_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [lms_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lms_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);
   import lms_pkg::*;

   localparam int ACC_W   = Q_W + 3;
   localparam int CFG_NUM = 8;

   localparam logic [2:0] CSR_COIL_RES  = 3'd0;
   localparam logic [2:0] CSR_BL        = 3'd1;
   localparam logic [2:0] CSR_IND       = 3'd2;
   localparam logic [2:0] CSR_MASS      = 3'd3;
   localparam logic [2:0] CSR_RMS       = 3'd4;
   localparam logic [2:0] CSR_AREA      = 3'd5;
   localparam logic [2:0] CSR_STIFF     = 3'd6;
   localparam logic [2:0] CSR_TIME_STEP = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BLV,
      ST_LI,
      ST_LIDT,
      ST_LDT,
      ST_INEW,
      ST_BLI,
      ST_PSD,
      ST_XK,
      ST_RMSU,
      ST_DAMP,
      ST_ACC,
      ST_VEL,
      ST_POS,
      ST_DONE
   } seq_state_type;

   logic [CFG_W-1:0]        cfg_ff [CFG_NUM];
   seq_state_type           state_ff;
   logic                    wait_ff;
   status_type              status_ff;
   logic signed [Q_W-1:0]   u_ff;
   logic signed [Q_W-1:0]   dp_ff;
   logic signed [Q_W-1:0]   msum_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [Q_W-1:0]   tmp_ff;
   logic signed [Q_W-1:0]   sum_ff;
   logic signed [Q_W-1:0]   den_ff;
   logic signed [Q_W-1:0]   inew_ff;
   logic signed [Q_W-1:0]   vnew_ff;
   logic signed [Q_W-1:0]   xnew_ff;
   logic signed [Q_W-1:0]   current_ff;
   logic signed [Q_W-1:0]   velocity_ff;
   logic signed [Q_W-1:0]   position_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   alu_ctrl_type            alu_ctrl;
   alu_stat_type            alu_stat;
   logic signed [Q_W-1:0]   alu_a;
   logic signed [Q_W-1:0]   alu_b;
   logic signed [Q_W-1:0]   alu_res;
   logic                    op_active;
   alu_op_type              op_sel;
   logic signed [ACC_W-1:0] acc_add;
   logic signed [ACC_W-1:0] acc_sub;
   logic                    cfg_wr;
   logic                    zero_param;
   logic                    updated;
   logic                    rsp_load;

   assign cfg_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < CFG_NUM; n++) begin
            cfg_ff[n] <= '0;
         end
      end else if (cfg_wr) begin
         cfg_ff[paddr[4:2]] <= pwdata[CFG_W-1:0];
      end
   end

   assign prdata = {1'b0, cfg_ff[paddr[4:2]]};
   assign pready = 1'b1;

   assign zero_param = (cfg_ff[CSR_COIL_RES] == '0) || (cfg_ff[CSR_AREA] == '0) ||
                       (cfg_ff[CSR_IND] == '0) || (cfg_ff[CSR_RMS] == '0) ||
                       (cfg_ff[CSR_STIFF] == '0) || (cfg_ff[CSR_BL] == '0) ||
                       (cfg_ff[CSR_MASS] == '0);

   always_comb begin
      op_active = 1'b1;
      op_sel    = ALU_MUL;
      alu_a     = '0;
      alu_b     = '0;
      unique case (state_ff)
         ST_BLV: begin
            alu_a = {1'b0, cfg_ff[CSR_BL]};
            alu_b = velocity_ff;
         end
         ST_LI: begin
            alu_a = {1'b0, cfg_ff[CSR_IND]};
            alu_b = current_ff;
         end
         ST_LIDT: begin
            op_sel = ALU_DIV;
            alu_a  = tmp_ff;
            alu_b  = {1'b0, cfg_ff[CSR_TIME_STEP]};
         end
         ST_LDT: begin
            op_sel = ALU_DIV;
            alu_a  = {1'b0, cfg_ff[CSR_IND]};
            alu_b  = {1'b0, cfg_ff[CSR_TIME_STEP]};
         end
         ST_INEW: begin
            op_sel = ALU_DIV;
            alu_a  = sum_ff;
            alu_b  = den_ff;
         end
         ST_BLI: begin
            alu_a = {1'b0, cfg_ff[CSR_BL]};
            alu_b = inew_ff;
         end
         ST_PSD: begin
            alu_a = dp_ff;
            alu_b = {1'b0, cfg_ff[CSR_AREA]};
         end
         ST_XK: begin
            alu_a = position_ff;
            alu_b = {1'b0, cfg_ff[CSR_STIFF]};
         end
         ST_RMSU: begin
            alu_a = {1'b0, cfg_ff[CSR_RMS]};
            alu_b = u_ff;
         end
         ST_DAMP: begin
            op_sel = ALU_DIV;
            alu_a  = tmp_ff;
            alu_b  = {1'b0, cfg_ff[CSR_BL]};
         end
         ST_ACC: begin
            op_sel = ALU_DIV;
            alu_a  = sum_ff;
            alu_b  = msum_ff;
         end
         ST_VEL: begin
            alu_a = tmp_ff;
            alu_b = {1'b0, cfg_ff[CSR_TIME_STEP]};
         end
         ST_POS: begin
            alu_a = vnew_ff;
            alu_b = {1'b0, cfg_ff[CSR_TIME_STEP]};
         end
         default: begin
            op_active = 1'b0;
         end
      endcase
   end

   assign alu_ctrl.start = op_active && !wait_ff;
   assign alu_ctrl.op    = op_sel;

   lms_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .opa    (alu_a),
      .opb    (alu_b),
      .stat   (alu_stat),
      .result (alu_res)
   );

   assign acc_add  = acc_ff + ACC_W'(alu_res);
   assign acc_sub  = acc_ff - ACC_W'(alu_res);
   assign updated  = (status_ff == STATUS_UPDATED);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         current_ff   <= '0;
         velocity_ff  <= '0;
         position_ff  <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (alu_ctrl.start) begin
            wait_ff <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  u_ff    <= req_data.drive_voltage;
                  dp_ff   <= sat32((2*Q_W)'(req_data.pressure_left) -
                                   (2*Q_W)'(req_data.pressure_right));
                  msum_ff <= sat32((2*Q_W)'({1'b0, cfg_ff[CSR_MASS]}) +
                                   (2*Q_W)'({1'b0, req_data.air_mass}));
                  acc_ff  <= ACC_W'(req_data.drive_voltage);
                  priority if (cfg_ff[CSR_TIME_STEP] == '0) begin
                     status_ff <= STATUS_SKIPPED;
                     state_ff  <= ST_DONE;
                  end else if (zero_param) begin
                     status_ff <= STATUS_PARAM_ERROR;
                     state_ff  <= ST_DONE;
                  end else begin
                     status_ff <= STATUS_UPDATED;
                     state_ff  <= ST_BLV;
                  end
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_ff.step_status        <= status_ff;
                  rsp_ff.coil_current       <= updated ? inew_ff : current_ff;
                  rsp_ff.diaphragm_velocity <= updated ? vnew_ff : velocity_ff;
                  rsp_ff.diaphragm_position <= updated ? xnew_ff : position_ff;
                  if (updated) begin
                     current_ff  <= inew_ff;
                     velocity_ff <= vnew_ff;
                     position_ff <= xnew_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               if (wait_ff && alu_stat.done) begin
                  wait_ff <= 1'b0;
                  unique case (state_ff)
                     ST_BLV: begin
                        acc_ff   <= acc_sub;
                        state_ff <= ST_LI;
                     end
                     ST_LI: begin
                        tmp_ff   <= alu_res;
                        state_ff <= ST_LIDT;
                     end
                     ST_LIDT: begin
                        sum_ff   <= sat32((2*Q_W)'(acc_add));
                        state_ff <= ST_LDT;
                     end
                     ST_LDT: begin
                        den_ff   <= sat32((2*Q_W)'({1'b0, cfg_ff[CSR_COIL_RES]}) +
                                          (2*Q_W)'(alu_res));
                        state_ff <= ST_INEW;
                     end
                     ST_INEW: begin
                        inew_ff  <= alu_res;
                        state_ff <= ST_BLI;
                     end
                     ST_BLI: begin
                        acc_ff   <= ACC_W'(alu_res);
                        state_ff <= ST_PSD;
                     end
                     ST_PSD: begin
                        acc_ff   <= acc_add;
                        state_ff <= ST_XK;
                     end
                     ST_XK: begin
                        acc_ff   <= acc_sub;
                        state_ff <= ST_RMSU;
                     end
                     ST_RMSU: begin
                        tmp_ff   <= alu_res;
                        state_ff <= ST_DAMP;
                     end
                     ST_DAMP: begin
                        sum_ff   <= sat32((2*Q_W)'(acc_sub));
                        state_ff <= ST_ACC;
                     end
                     ST_ACC: begin
                        tmp_ff   <= alu_res;
                        state_ff <= ST_VEL;
                     end
                     ST_VEL: begin
                        vnew_ff  <= sat32((2*Q_W)'(velocity_ff) + (2*Q_W)'(alu_res));
                        state_ff <= ST_POS;
                     end
                     ST_POS: begin
                        xnew_ff  <= sat32((2*Q_W)'(position_ff) + (2*Q_W)'(alu_res));
                        state_ff <= ST_DONE;
                     end
                     default: begin
                        state_ff <= state_ff;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LMS_ASSERT_NXT(a_zero_dt_skips, clock, reset, req_valid && !req_stall && (cfg_ff[CSR_TIME_STEP] == '0), (state_ff == ST_DONE) && (status_ff == STATUS_SKIPPED))
   `LMS_ASSERT_IMP(a_done_while_waiting, clock, reset, alu_stat.done, wait_ff)
   `LMS_ASSERT_NXT(a_state_holds, clock, reset, state_ff != ST_DONE, $stable(current_ff) && $stable(velocity_ff) && $stable(position_ff))
   `LMS_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_DONE))

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Loudspeaker motion step testbench
// Drives request items through bursts and gaps while the response side stalls
// on its own pattern, programs the eight model parameters over the register
// port between phases, and checks every response item against a cycle-free
// fixed-point predictor of the coil current, velocity and position update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import lms_pkg::*;

   localparam int     NUM_PARAMS      = 8;
   localparam int     ITEMS_PER_PHASE = 163;
   localparam int     NUM_PHASES      = 10;
   localparam int     WATCHDOG_LIMIT  = 3000;
   localparam int     END_CYCLES      = 200;
   localparam longint Q_HI            = 64'sh0000_0000_7fff_ffff;
   localparam longint Q_LO            = -64'sh0000_0000_8000_0000;

   typedef enum int {
      REG_COIL_RESISTANCE,
      REG_FORCE_FACTOR,
      REG_COIL_INDUCTANCE,
      REG_MOVING_MASS,
      REG_MECH_RESISTANCE,
      REG_DIAPHRAGM_AREA,
      REG_SPRING_STIFFNESS,
      REG_TIME_STEP
   } param_index_type;

   typedef enum int {
      CFG_MODERATE,
      CFG_ALL_MAX,
      CFG_ALL_ONE,
      CFG_FULL_RANDOM,
      CFG_ZERO_DT
   } cfg_style_type;

   class motion_scoreboard_type;
      int      param_q[NUM_PARAMS];
      int      cur_q;
      int      vel_q;
      int      pos_q;
      int      failures;
      rsp_type expected_steps[$];

      function new();
         foreach (param_q[r]) param_q[r] = 0;
         cur_q    = 0;
         vel_q    = 0;
         pos_q    = 0;
         failures = 0;
      endfunction

      function void write_param(param_index_type idx, logic [31:0] value);
         param_q[idx] = int'({1'b0, value[30:0]});
      endfunction

      function int pending();
         return expected_steps.size();
      endfunction

      function int clamp_q(longint v);
         if (v > Q_HI) return int'(Q_HI);
         if (v < Q_LO) return int'(Q_LO);
         return int'(v);
      endfunction

      function int fx_mul(int a, int b);
         longint prod;
         prod = longint'(a) * longint'(b);
         return clamp_q(prod >>> FRAC_BITS);
      endfunction

      function int fx_div(int a, int b);
         longint scaled;
         scaled = longint'(a) <<< FRAC_BITS;
         if (b == 0) begin
            if (a > 0) return int'(Q_HI);
            if (a < 0) return int'(Q_LO);
            return 0;
         end
         return clamp_q(scaled / longint'(b));
      endfunction

      function void advance_model(req_type d);
         int      re, bl, ind, m, rms, sd, k, dt;
         int      u, pl, pr, air;
         int      num, den, inew, fsum, msum, acc, vnew, xnew;
         rsp_type e;
         re  = param_q[REG_COIL_RESISTANCE];
         bl  = param_q[REG_FORCE_FACTOR];
         ind = param_q[REG_COIL_INDUCTANCE];
         m   = param_q[REG_MOVING_MASS];
         rms = param_q[REG_MECH_RESISTANCE];
         sd  = param_q[REG_DIAPHRAGM_AREA];
         k   = param_q[REG_SPRING_STIFFNESS];
         dt  = param_q[REG_TIME_STEP];
         u   = d.drive_voltage;
         pl  = d.pressure_left;
         pr  = d.pressure_right;
         air = int'({1'b0, d.air_mass});
         if (dt == 0) begin
            e.step_status = STATUS_SKIPPED;
         end else if (re == 0 || sd == 0 || ind == 0 || rms == 0 || k == 0 ||
                      bl == 0 || m == 0) begin
            e.step_status = STATUS_PARAM_ERROR;
         end else begin
            num  = clamp_q(longint'(u) - fx_mul(bl, vel_q)
                           + fx_div(fx_mul(ind, cur_q), dt));
            den  = clamp_q(longint'(re) + fx_div(ind, dt));
            inew = fx_div(num, den);
            fsum = clamp_q(longint'(fx_mul(bl, inew))
                           + fx_mul(clamp_q(longint'(pl) - pr), sd)
                           - fx_mul(pos_q, k)
                           - fx_div(fx_mul(rms, u), bl));
            msum = clamp_q(longint'(m) + air);
            acc  = fx_div(fsum, msum);
            vnew = clamp_q(longint'(vel_q) + fx_mul(acc, dt));
            xnew = clamp_q(longint'(pos_q) + fx_mul(vnew, dt));
            cur_q = inew;
            vel_q = vnew;
            pos_q = xnew;
            e.step_status = STATUS_UPDATED;
         end
         e.coil_current       = cur_q;
         e.diaphragm_velocity = vel_q;
         e.diaphragm_position = pos_q;
         expected_steps.push_back(e);
      endfunction

      function void check_step(rsp_type got);
         rsp_type e;
         if (expected_steps.size() == 0) begin
            $error("unexpected result item: step_status %0d", got.step_status);
            failures++;
            return;
         end
         e = expected_steps.pop_front();
         if (got.step_status !== e.step_status) begin
            $error("step_status: expected %0d, actual %0d", e.step_status, got.step_status);
            failures++;
         end
         if (got.coil_current !== e.coil_current) begin
            $error("coil_current: expected %0d, actual %0d",
                   e.coil_current, got.coil_current);
            failures++;
         end
         if (got.diaphragm_velocity !== e.diaphragm_velocity) begin
            $error("diaphragm_velocity: expected %0d, actual %0d",
                   e.diaphragm_velocity, got.diaphragm_velocity);
            failures++;
         end
         if (got.diaphragm_position !== e.diaphragm_position) begin
            $error("diaphragm_position: expected %0d, actual %0d",
                   e.diaphragm_position, got.diaphragm_position);
            failures++;
         end
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   motion_scoreboard_type sb;
   int               idle_cycles = 0;
   int               stall_run   = 0;
   int               stall_level = 0;
   int               level_age   = 0;

   loudspeaker_motion_step dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (level_age == 0) begin
         stall_level <= $urandom_range(0, 3);
         level_age   <= $urandom_range(200, 800);
      end else begin
         level_age <= level_age - 1;
      end
      if (stall_run == 0) begin
         rsp_stall <= ($urandom_range(0, 3) < stall_level);
         stall_run <= $urandom_range(1, 24);
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.advance_model(req_data);
         if (rsp_valid && !rsp_stall) sb.check_step(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic logic [31:0] pick_q();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'h0;
         3, 4, 5: return r;
         default: return {{11{r[20]}}, r[20:0]};
      endcase
   endfunction

   function automatic logic [30:0] pick_air();
      case ($urandom_range(0, 7))
         0:       return 31'h0;
         1:       return 31'h7fff_ffff;
         2, 3:    return 31'($urandom);
         default: return 31'($urandom_range(0, 32'h4_0000));
      endcase
   endfunction

   function automatic req_type make_req(logic [31:0] u, logic [31:0] pl,
                                        logic [31:0] pr, logic [30:0] air);
      req_type d;
      d.drive_voltage  = u;
      d.pressure_left  = pl;
      d.pressure_right = pr;
      d.air_mass       = air;
      return d;
   endfunction

   task automatic send_item(input req_type d);
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drain();
      do @(negedge clock); while (sb.pending() != 0);
      @(posedge clock);
   endtask

   task automatic csr_write(input param_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * idx);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.write_param(idx, value);
   endtask

   task automatic apply_config(input cfg_style_type style, input int zero_reg);
      logic [31:0] value;
      req_valid <= 1'b0;
      wait_drain();
      for (int r = 0; r < NUM_PARAMS; r++) begin
         case (style)
            CFG_ALL_MAX:     value = 32'hffff_ffff;
            CFG_ALL_ONE:     value = 32'h1;
            CFG_FULL_RANDOM: value = $urandom;
            default: begin
               if (r == REG_TIME_STEP) value = $urandom_range(32'h100, 32'h4000);
               else value = $urandom_range(32'h400, 32'h10_0000);
            end
         endcase
         if (r == zero_reg || (style == CFG_ZERO_DT && r == REG_TIME_STEP)) value = '0;
         csr_write(param_index_type'(r), value);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int sent;
      int burst;
      int gap;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(make_req(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff));
      apply_config(CFG_ZERO_DT, -1);
      send_item(make_req(pick_q(), pick_q(), pick_q(), pick_air()));
      for (int r = 0; r < REG_TIME_STEP; r++) begin
         apply_config(CFG_MODERATE, r);
         send_item(make_req(pick_q(), pick_q(), pick_q(), pick_air()));
      end

      apply_config(CFG_MODERATE, -1);
      send_item(make_req(32'h7fff_ffff, 32'h0, 32'h0, 31'h0));
      send_item(make_req(32'h8000_0000, 32'h0, 32'h0, 31'h0));
      send_item(make_req(32'h0, 32'h0, 32'h0, 31'h0));
      send_item(make_req(32'h0, 32'h7fff_ffff, 32'h8000_0000, 31'h0));
      send_item(make_req(32'h0, 32'h8000_0000, 32'h7fff_ffff, 31'h0));
      send_item(make_req(32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 31'h7fff_ffff));
      send_item(make_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff));

      apply_config(CFG_ALL_MAX, -1);
      send_item(make_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff));
      send_item(make_req(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 31'h0));
      send_item(make_req(32'h0, 32'h0, 32'h0, 31'h0));

      apply_config(CFG_ALL_ONE, -1);
      send_item(make_req(32'h1, 32'h0, 32'h0, 31'h0));
      send_item(make_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 31'h0));
      send_item(make_req(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff));

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0:       apply_config(CFG_FULL_RANDOM, -1);
            1:       apply_config(CFG_ALL_MAX, -1);
            2:       apply_config(CFG_ALL_ONE, -1);
            3:       apply_config(CFG_ZERO_DT, -1);
            4:       apply_config(CFG_MODERATE, $urandom_range(0, 6));
            default: apply_config(CFG_MODERATE, -1);
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
               send_item(make_req(pick_q(), pick_q(), pick_q(), pick_air()));
               sent++;
            end
            if ($urandom_range(0, 29) == 0) begin
               req_valid <= 1'b0;
               wait_drain();
            end else begin
               gap = $urandom_range(0, 14);
               if (gap != 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
         end
      end

      req_valid <= 1'b0;
      wait_drain();
      repeat (END_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         if (sb.pending() != 0) $error("%0d expected result items never arrived", sb.pending());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* loudspeaker_motion_step.f */
+incdir+rtl
rtl/lms_pkg.sv
rtl/lms_alu.sv
rtl/loudspeaker_motion_step.sv
sim/testbench.sv
